// ===== src/multi_channel_soft_timer_bank_unit_assert.svh =====
// Assertion macros for the soft timer bank.
`ifndef MULTI_CHANNEL_SOFT_TIMER_BANK_UNIT_ASSERT_SVH
`define MULTI_CHANNEL_SOFT_TIMER_BANK_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// expr holds at every clock edge outside reset
`define MCSTB_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// ante implies cons in the same cycle
`define MCSTB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`else

`define MCSTB_ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define MCSTB_ASSERT_IMPL(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== src/mcstb_pkg.sv =====
`timescale 1ns / 1ps

package mcstb_pkg;

   localparam int KIND_WIDTH   = 3;
   localparam int ID_WIDTH     = 4;
   localparam int AMOUNT_WIDTH = 32;

   // most expiries reported by one service item
   localparam int MAX_RESULTS      = 16;
   localparam int REPORT_CNT_WIDTH = $clog2(MAX_RESULTS + 1);

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_CREATE  = 3'd0,
      KIND_KILL    = 3'd1,
      KIND_START   = 3'd2,
      KIND_STOP    = 3'd3,
      KIND_ADVANCE = 3'd4,
      KIND_SERVICE = 3'd5
   } kind_type;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]   kind;
      logic [ID_WIDTH-1:0]     timer_id;
      logic [AMOUNT_WIDTH-1:0] amount;
      logic                    reload_enable;
   } req_item_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0] slot_id;
      logic                ok;
      logic                running;
      logic                expired_event;
      logic                last;
   } rsp_item_type;

endpackage

// ===== src/mcstb_if.sv =====
`timescale 1ns / 1ps

// Command channel
interface mcstb_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [mcstb_pkg::KIND_WIDTH-1:0]     kind;
   logic [mcstb_pkg::ID_WIDTH-1:0]       timer_id;
   logic [mcstb_pkg::AMOUNT_WIDTH-1:0]   amount;
   logic                                 reload_enable;

   modport source (output valid, kind, timer_id, amount, reload_enable, input ready);
   modport sink   (input valid, kind, timer_id, amount, reload_enable, output ready);
endinterface

// Result channel
interface mcstb_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mcstb_pkg::ID_WIDTH-1:0] slot_id;
   logic                           ok;
   logic                           running;
   logic                           expired_event;
   logic                           last;

   modport source (output valid, slot_id, ok, running, expired_event, last, input ready);
   modport sink   (input valid, slot_id, ok, running, expired_event, last, output ready);
endinterface

// ===== src/mcstb_adv_unit.sv =====
`timescale 1ns / 1ps

// Shared add and compare for one slot of an advance sweep.
module mcstb_adv_unit #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic [COUNT_WIDTH-1:0] count,
   input  logic [COUNT_WIDTH-1:0] timeout,
   input  logic [COUNT_WIDTH-1:0] elapsed,
   output logic                   reached,
   output logic [COUNT_WIDTH-1:0] new_count
);

   logic [COUNT_WIDTH:0] sum;
   logic [COUNT_WIDTH:0] excess;

   assign sum     = {1'b0, count} + {1'b0, elapsed};
   assign excess  = sum - {1'b0, timeout};
   assign reached = (sum >= {1'b0, timeout});

   always_comb begin
      if (!reached) begin
         new_count = sum[COUNT_WIDTH-1:0];
      end else if (elapsed > timeout) begin
         new_count = '0;
      end else begin
         new_count = excess[COUNT_WIDTH-1:0];
      end
   end

endmodule

// ===== src/multi_channel_soft_timer_bank_unit.sv =====
`timescale 1ns / 1ps
// Soft timer bank: NUM_TIMERS slots, each with a timeout, a count and
// periodic or one-shot reload, driven by command items on req_ch.
// Results leave on rsp_ch, one item per command, except service, which
// gives one item per expired slot reported (at most 16), with last set on
// the final one, or one empty item if no slot has expired.
// Steps, from acceptance to the result loaded in the output register:
//   create, kill, start, stop, unused kinds: ST_SINGLE, once the output is free.
//   advance: the sweep runs every slot through the one shared adder/comparator,
//            one slot a cycle, behind a registered read of the count and
//            timeout memories; ST_RESP then loads the result.
//   service: the sweep checks one slot a cycle, pausing while a stalled
//            receiver blocks a report, and holds one report back until it
//            knows whether that report is the final one.
// One item is in work at a time; req_ch.ready is high only while idle, but a
// new item is taken while the previous result still waits in the output
// register. A stalled receiver holds the result and, for service, pauses the
// sweep once a second report is ready.
// Reset clears the created, active, enabled and expired flags at once; no
// clearing pass is needed: counts, timeouts and reload flags are written before use.
module multi_channel_soft_timer_bank_unit #(
   parameter int NUM_TIMERS  = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   mcstb_req_if.sink         req_ch,
   mcstb_rsp_if.source       rsp_ch
);

`include "multi_channel_soft_timer_bank_unit_assert.svh"

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);
   localparam int NW    = mcstb_pkg::REPORT_CNT_WIDTH;
   localparam int IDW   = mcstb_pkg::ID_WIDTH;
   localparam int AW    = mcstb_pkg::AMOUNT_WIDTH;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_SINGLE  = 6'b000010,
      ST_ADV     = 6'b000100,
      ST_RESP    = 6'b001000,
      ST_SVC     = 6'b010000,
      ST_SVC_END = 6'b100000
   } state_type;

   // report held back during a service sweep
   typedef struct packed {
      logic [IDW-1:0] slot_id;
      logic           running;
   } pend_type;

   state_type                 state_ff, state_in;
   mcstb_pkg::req_item_type   cmd_ff, cmd_in;
   mcstb_pkg::rsp_item_type   out_ff, out_in;
   logic                      out_valid_ff, out_valid_in;

   // per-slot flags
   logic [NUM_TIMERS-1:0]     created_ff, created_in;
   logic [NUM_TIMERS-1:0]     active_ff, active_in;
   logic [NUM_TIMERS-1:0]     enabled_ff, enabled_in;
   logic [NUM_TIMERS-1:0]     expired_ff, expired_in;
   logic [NUM_TIMERS-1:0]     reload_ff;

   // sweep control
   logic [CNT_W-1:0]          k_ff, k_in;
   logic                      s_valid_ff, s_valid_in;
   logic [IDX_W-1:0]          s_idx_ff, s_idx_in;
   logic [NW-1:0]             n_ff, n_in;
   logic                      pend_valid_ff, pend_valid_in;
   pend_type                  pend_ff, pend_in;

   // count and timeout storage
   logic [COUNT_WIDTH-1:0]    timeout_mem [NUM_TIMERS];
   logic [COUNT_WIDTH-1:0]    count_mem [NUM_TIMERS];
   logic [COUNT_WIDTH-1:0]    rd_to_ff;
   logic [COUNT_WIDTH-1:0]    rd_cnt_ff;
   logic [IDX_W-1:0]          rd_addr;
   logic                      cnt_we;
   logic [IDX_W-1:0]          cnt_wa;
   logic [COUNT_WIDTH-1:0]    cnt_wd;
   logic                      to_we;
   logic                      reload_we;

   // command decode
   logic [IDX_W+IDW-1:0]      id_ext;
   logic [IDX_W-1:0]          idx;
   logic                      in_range;
   logic [COUNT_WIDTH+AW-1:0] amt_ext;
   logic [COUNT_WIDTH-1:0]    amt;
   logic [IDX_W-1:0]          kidx;
   logic [IDX_W+IDW-1:0]      k_ext;
   logic                      sweep_done;
   logic                      out_free;

   logic                      adv_reached;
   logic [COUNT_WIDTH-1:0]    adv_count;

   assign id_ext     = {{IDX_W{1'b0}}, cmd_ff.timer_id};
   assign idx        = id_ext[IDX_W-1:0];
   assign in_range   = (32'(cmd_ff.timer_id) < 32'(NUM_TIMERS));
   assign amt_ext    = {{COUNT_WIDTH{1'b0}}, cmd_ff.amount};
   assign amt        = amt_ext[COUNT_WIDTH-1:0];
   assign kidx       = k_ff[IDX_W-1:0];
   assign k_ext      = {{IDW{1'b0}}, kidx};
   assign sweep_done = (k_ff == CNT_W'(NUM_TIMERS));
   assign out_free   = !out_valid_ff || rsp_ch.ready;

   mcstb_adv_unit #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_adv (
      .count     (rd_cnt_ff),
      .timeout   (rd_to_ff),
      .elapsed   (amt),
      .reached   (adv_reached),
      .new_count (adv_count)
   );

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.slot_id       = out_ff.slot_id;
   assign rsp_ch.ok            = out_ff.ok;
   assign rsp_ch.running       = out_ff.running;
   assign rsp_ch.expired_event = out_ff.expired_event;
   assign rsp_ch.last          = out_ff.last;

   always_comb begin
      logic ok;
      ok            = 1'b0;
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      created_in    = created_ff;
      active_in     = active_ff;
      enabled_in    = enabled_ff;
      expired_in    = expired_ff;
      k_in          = k_ff;
      s_valid_in    = 1'b0;
      s_idx_in      = s_idx_ff;
      n_in          = n_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_in        = out_ff;
      cnt_we        = 1'b0;
      cnt_wa        = idx;
      cnt_wd        = '0;
      to_we         = 1'b0;
      reload_we     = 1'b0;
      rd_addr       = kidx;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               cmd_in.kind          = req_ch.kind;
               cmd_in.timer_id      = req_ch.timer_id;
               cmd_in.amount        = req_ch.amount;
               cmd_in.reload_enable = req_ch.reload_enable;
               k_in                 = '0;
               n_in                 = '0;
               pend_valid_in        = 1'b0;
               priority if (req_ch.kind == mcstb_pkg::KIND_ADVANCE) begin
                  state_in = ST_ADV;
               end else if (req_ch.kind == mcstb_pkg::KIND_SERVICE) begin
                  state_in = ST_SVC;
               end else begin
                  state_in = ST_SINGLE;
               end
            end
         end

         ST_SINGLE: begin
            if (out_free) begin
               if (in_range) begin
                  unique case (cmd_ff.kind)
                     mcstb_pkg::KIND_CREATE: begin
                        if (!created_ff[idx]) begin
                           created_in[idx] = 1'b1;
                           active_in[idx]  = 1'b0;
                           enabled_in[idx] = 1'b0;
                           expired_in[idx] = 1'b0;
                           to_we           = 1'b1;
                           reload_we       = 1'b1;
                           cnt_we          = 1'b1;
                           ok              = 1'b1;
                        end
                     end
                     mcstb_pkg::KIND_KILL: begin
                        if (created_ff[idx]) begin
                           created_in[idx] = 1'b0;
                           active_in[idx]  = 1'b0;
                           enabled_in[idx] = 1'b0;
                           expired_in[idx] = 1'b0;
                           ok              = 1'b1;
                        end
                     end
                     mcstb_pkg::KIND_START: begin
                        if (active_ff[idx]) begin
                           enabled_in[idx] = 1'b1;
                           ok              = 1'b1;
                        end else if (created_ff[idx]) begin
                           active_in[idx]  = 1'b1;
                           enabled_in[idx] = 1'b1;
                           expired_in[idx] = 1'b0;
                           cnt_we          = 1'b1;
                           ok              = 1'b1;
                        end
                     end
                     mcstb_pkg::KIND_STOP: begin
                        if (active_ff[idx]) begin
                           active_in[idx]  = 1'b0;
                           enabled_in[idx] = 1'b0;
                           expired_in[idx] = 1'b0;
                           cnt_we          = 1'b1;
                        end
                        ok = 1'b1;
                     end
                     default: begin
                        ok = 1'b0;
                     end
                  endcase
               end
               // unused kinds report the slot as not running
               out_in = '{slot_id: cmd_ff.timer_id, ok: ok,
                          running: in_range && (cmd_ff.kind < mcstb_pkg::KIND_ADVANCE) &&
                                   active_in[idx] && enabled_in[idx],
                          expired_event: 1'b0, last: 1'b1};
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_ADV: begin
            // read slot k while slot s_idx (k - 1) goes through the adder
            if (!sweep_done) begin
               s_valid_in = 1'b1;
               s_idx_in   = kidx;
               k_in       = k_ff + CNT_W'(1);
            end else begin
               state_in = ST_RESP;
            end
            if (s_valid_ff && active_ff[s_idx_ff] && enabled_ff[s_idx_ff] &&
                !expired_ff[s_idx_ff]) begin
               cnt_we = 1'b1;
               cnt_wa = s_idx_ff;
               cnt_wd = adv_count;
               if (adv_reached) begin
                  expired_in[s_idx_ff] = 1'b1;
                  enabled_in[s_idx_ff] = reload_ff[s_idx_ff];
               end
            end
         end

         ST_RESP: begin
            if (out_free) begin
               out_in = '{slot_id: '0, ok: 1'b1, running: 1'b0,
                          expired_event: 1'b0, last: 1'b1};
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_SVC: begin
            if (sweep_done || n_ff == NW'(mcstb_pkg::MAX_RESULTS)) begin
               state_in = ST_SVC_END;
            end else if (!(active_ff[kidx] && expired_ff[kidx])) begin
               k_in = k_ff + CNT_W'(1);
            end else if (!pend_valid_ff || out_free) begin
               // a new hit proves the held report is not the final one
               if (pend_valid_ff) begin
                  out_in = '{slot_id: pend_ff.slot_id, ok: 1'b1,
                             running: pend_ff.running, expired_event: 1'b1,
                             last: 1'b0};
                  out_valid_in = 1'b1;
               end
               pend_in       = '{slot_id: k_ext[IDW-1:0], running: enabled_ff[kidx]};
               pend_valid_in = 1'b1;
               expired_in[kidx] = 1'b0;
               n_in          = n_ff + NW'(1);
               k_in          = k_ff + CNT_W'(1);
            end
         end

         ST_SVC_END: begin
            if (out_free) begin
               if (pend_valid_ff) begin
                  out_in = '{slot_id: pend_ff.slot_id, ok: 1'b1,
                             running: pend_ff.running, expired_event: 1'b1,
                             last: 1'b1};
               end else begin
                  out_in = '{slot_id: '0, ok: 1'b1, running: 1'b0,
                             expired_event: 1'b0, last: 1'b1};
               end
               out_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         created_ff    <= '0;
         active_ff     <= '0;
         enabled_ff    <= '0;
         expired_ff    <= '0;
         out_valid_ff  <= 1'b0;
         s_valid_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         k_ff          <= '0;
         n_ff          <= '0;
      end else begin
         state_ff      <= state_in;
         created_ff    <= created_in;
         active_ff     <= active_in;
         enabled_ff    <= enabled_in;
         expired_ff    <= expired_in;
         out_valid_ff  <= out_valid_in;
         s_valid_ff    <= s_valid_in;
         pend_valid_ff <= pend_valid_in;
         k_ff          <= k_in;
         n_ff          <= n_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      out_ff   <= out_in;
      pend_ff  <= pend_in;
      s_idx_ff <= s_idx_in;
      if (reload_we) begin
         reload_ff[idx] <= cmd_ff.reload_enable;
      end
   end

   // count and timeout memories, one write and one registered read each
   always_ff @(posedge clock) begin
      if (to_we) begin
         timeout_mem[idx] <= amt;
      end
      if (cnt_we) begin
         count_mem[cnt_wa] <= cnt_wd;
      end
      rd_to_ff  <= timeout_mem[rd_addr];
      rd_cnt_ff <= count_mem[rd_addr];
   end

   `MCSTB_ASSERT_ALWAYS(a_active_needs_created, clock, reset, (active_ff & ~created_ff) == '0, "active slot not created")
   `MCSTB_ASSERT_ALWAYS(a_flags_need_active, clock, reset, ((enabled_ff | expired_ff) & ~active_ff) == '0, "enabled or expired slot not active")
   `MCSTB_ASSERT_IMPL(a_adv_stage_in_sweep, clock, reset, s_valid_ff, state_ff == ST_ADV, "advance stage busy outside sweep")
   `MCSTB_ASSERT_IMPL(a_pend_in_service, clock, reset, pend_valid_ff, (state_ff == ST_SVC || state_ff == ST_SVC_END) && n_ff != '0, "held report outside service")

endmodule

// ===== dv/multi_channel_soft_timer_bank_unit_tb.sv =====
`timescale 1ns / 1ps

// Soft timer bank testbench: a directed pass over the commands and corner cases,
// then random command traffic under four idling phases. Each accepted item
// updates a private copy of the bank, and the reports that item should produce
// are queued. The result channel is checked in order, field by field.
module multi_channel_soft_timer_bank_unit_tb;

   localparam int NUM_SLOTS = 16;
   localparam int COUNT_W   = 32;
   localparam int KW        = mcstb_pkg::KIND_WIDTH;
   localparam int IW        = mcstb_pkg::ID_WIDTH;

   // the two kind codes that the bank does not use
   localparam logic [KW-1:0] KIND_SPARE_A = 3'd6;
   localparam logic [KW-1:0] KIND_SPARE_B = 3'd7;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   logic clock = 1'b0;
   logic reset;

   mcstb_req_if req_ch ();
   mcstb_rsp_if rsp_ch ();

   multi_channel_soft_timer_bank_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // 10 ns period: high half, then low half
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow copy of the bank, kept in step with accepted items
   // ------------------------------------------------------------------
   bit                 slot_made     [NUM_SLOTS];
   bit                 slot_live     [NUM_SLOTS];   // in the active set
   bit                 slot_on       [NUM_SLOTS];   // enabled
   bit                 slot_fired    [NUM_SLOTS];   // expired, not yet serviced
   bit                 slot_periodic [NUM_SLOTS];
   logic [COUNT_W-1:0] slot_limit    [NUM_SLOTS];
   logic [COUNT_W-1:0] slot_ticks    [NUM_SLOTS];

   // reports still owed by the bank, oldest first
   mcstb_pkg::rsp_item_type owed_reports[$];

   bit mismatch_seen = 1'b0;
   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;

   function automatic mcstb_pkg::rsp_item_type make_report(input logic [IW-1:0] id,
                                                           input logic ok,
                                                           input logic run,
                                                           input logic ev,
                                                           input logic fin);
      mcstb_pkg::rsp_item_type r;
      r.slot_id       = id;
      r.ok            = ok;
      r.running       = run;
      r.expired_event = ev;
      r.last          = fin;
      return r;
   endfunction

   // Every running, unexpired slot takes the elapsed time. Reaching the timeout
   // is judged on the full sum, carry included; an elapsed time beyond the
   // timeout drops the excess rather than carrying it.
   function automatic void advance_slots(input logic [COUNT_W-1:0] elapsed);
      logic [COUNT_W:0] sum;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (slot_live[i] && slot_on[i] && !slot_fired[i]) begin
            sum = {1'b0, slot_ticks[i]} + {1'b0, elapsed};
            if (sum[COUNT_W] || sum[COUNT_W-1:0] >= slot_limit[i]) begin
               slot_ticks[i] = (elapsed > slot_limit[i]) ? '0 :
                               sum[COUNT_W-1:0] - slot_limit[i];
               slot_fired[i] = 1'b1;
               slot_on[i]    = slot_periodic[i];
            end else begin
               slot_ticks[i] = sum[COUNT_W-1:0];
            end
         end
      end
   endfunction

   // One report per active, expired slot in slot order; a single empty report
   // if nothing has expired. The last report is held back to mark it final.
   function automatic void service_slots();
      mcstb_pkg::rsp_item_type held;
      int                      n = 0;
      for (int i = 0; i < NUM_SLOTS && n < mcstb_pkg::MAX_RESULTS; i++) begin
         if (slot_live[i] && slot_fired[i]) begin
            slot_fired[i] = 1'b0;
            if (n > 0)
               owed_reports.push_back(held);
            held = make_report(i[IW-1:0], 1'b1, slot_on[i], 1'b1, 1'b0);
            n++;
         end
      end
      if (n == 0) begin
         owed_reports.push_back(make_report('0, 1'b1, 1'b0, 1'b0, 1'b1));
      end else begin
         held.last = 1'b1;
         owed_reports.push_back(held);
      end
   endfunction

   function automatic void apply_timer_command(input logic [KW-1:0] kind,
                                               input logic [IW-1:0] id,
                                               input logic [COUNT_W-1:0] amount,
                                               input logic reload);
      int  s = id;
      bit  ok = 1'b0;
      case (kind)
         mcstb_pkg::KIND_ADVANCE: begin
            advance_slots(amount);
            owed_reports.push_back(make_report('0, 1'b1, 1'b0, 1'b0, 1'b1));
         end
         mcstb_pkg::KIND_SERVICE:
            service_slots();
         mcstb_pkg::KIND_CREATE, mcstb_pkg::KIND_KILL, mcstb_pkg::KIND_START,
         mcstb_pkg::KIND_STOP: begin
            case (kind)
               mcstb_pkg::KIND_CREATE:
                  if (!slot_made[s]) begin
                     slot_made[s]     = 1'b1;
                     slot_limit[s]    = amount;
                     slot_ticks[s]    = '0;
                     slot_periodic[s] = reload;
                     slot_live[s]     = 1'b0;
                     slot_on[s]       = 1'b0;
                     slot_fired[s]    = 1'b0;
                     ok = 1'b1;
                  end
               mcstb_pkg::KIND_KILL:
                  if (slot_made[s]) begin
                     slot_made[s]  = 1'b0;
                     slot_live[s]  = 1'b0;
                     slot_on[s]    = 1'b0;
                     slot_fired[s] = 1'b0;
                     ok = 1'b1;
                  end
               mcstb_pkg::KIND_START:
                  // a restart of an active slot keeps count and expiry mark
                  if (slot_live[s]) begin
                     slot_on[s] = 1'b1;
                     ok = 1'b1;
                  end else if (slot_made[s]) begin
                     slot_live[s]  = 1'b1;
                     slot_on[s]    = 1'b1;
                     slot_fired[s] = 1'b0;
                     slot_ticks[s] = '0;
                     ok = 1'b1;
                  end
               default: begin
                  // stop never fails, even on an absent slot
                  if (slot_live[s]) begin
                     slot_live[s]  = 1'b0;
                     slot_on[s]    = 1'b0;
                     slot_fired[s] = 1'b0;
                     slot_ticks[s] = '0;
                  end
                  ok = 1'b1;
               end
            endcase
            owed_reports.push_back(make_report(id, ok, slot_live[s] && slot_on[s],
                                               1'b0, 1'b1));
         end
         default:
            // spare kind codes: no change, a single refusal
            owed_reports.push_back(make_report(id, 1'b0, 1'b0, 1'b0, 1'b1));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Command driver: fields change on the falling edge, and the item is taken
   // at the rising edge where valid and ready are both high. valid is left
   // high on return; the next call either lowers it for an idle gap or
   // presents the next item, so it is never written twice in one step.
   // ------------------------------------------------------------------
   task automatic send_command(input logic [KW-1:0] kind,
                               input logic [IW-1:0] id,
                               input logic [COUNT_W-1:0] amount,
                               input logic reload);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.kind          <= kind;
      req_ch.timer_id      <= id;
      req_ch.amount        <= amount;
      req_ch.reload_enable <= reload;
      do @(posedge clock); while (!req_ch.ready);
      apply_timer_command(kind, id, amount, reload);
      @(negedge clock);
   endtask

   // Receiver back-pressure, redrawn every cycle
   always @(negedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);

   task automatic check_field(input string name, input int exp_val, input int act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name,
                  exp_val, act_val);
         mismatch_seen = 1'b1;
      end
   endtask

   // Result checker: each accepted item against the oldest owed report
   always @(posedge clock) begin
      mcstb_pkg::rsp_item_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (owed_reports.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual slot %0d ok %0b",
                     $realtime, rsp_ch.slot_id, rsp_ch.ok);
            mismatch_seen = 1'b1;
         end else begin
            exp_r = owed_reports.pop_front();
            check_field("slot_id",       exp_r.slot_id,       rsp_ch.slot_id);
            check_field("ok",            exp_r.ok,            rsp_ch.ok);
            check_field("running",       exp_r.running,       rsp_ch.running);
            check_field("expired_event", exp_r.expired_event, rsp_ch.expired_event);
            check_field("last",          exp_r.last,          rsp_ch.last);
         end
      end
   end

   // ------------------------------------------------------------------
   // Directed tests
   // ------------------------------------------------------------------

   // Create, duplicate create, kill, and commands on absent slots
   task automatic test_slot_lifecycle();
      send_command(mcstb_pkg::KIND_CREATE, 4'd15, COUNT_MAX, 1'b0);
      send_command(mcstb_pkg::KIND_CREATE, 4'd15, 32'd5, 1'b1);    // already exists
      send_command(mcstb_pkg::KIND_KILL,   4'd15, '0, 1'b0);
      send_command(mcstb_pkg::KIND_KILL,   4'd15, '0, 1'b0);       // absent
      send_command(mcstb_pkg::KIND_START,  4'd15, '0, 1'b0);       // absent
      send_command(mcstb_pkg::KIND_STOP,   4'd7,  '0, 1'b0);       // absent, still ok
   endtask

   // Counting, carry past the top of the count, excess dropped, periodic and
   // one-shot expiry, restart of a running slot, zero timeout, empty service
   task automatic test_expiry_and_reload();
      send_command(mcstb_pkg::KIND_CREATE,  4'd0, 32'd10, 1'b1);
      send_command(mcstb_pkg::KIND_START,   4'd0, '0, 1'b0);
      send_command(mcstb_pkg::KIND_START,   4'd0, '0, 1'b0);       // already running
      send_command(mcstb_pkg::KIND_ADVANCE, 4'd0, 32'd4, 1'b0);
      send_command(mcstb_pkg::KIND_ADVANCE, 4'd0, COUNT_MAX, 1'b0); // carry out, excess dropped
      send_command(mcstb_pkg::KIND_SERVICE, 4'd0, '0, 1'b0);
      send_command(mcstb_pkg::KIND_SERVICE, 4'd0, '0, 1'b0);       // nothing left to report
      send_command(mcstb_pkg::KIND_CREATE,  4'd15, COUNT_MAX, 1'b0);
      send_command(mcstb_pkg::KIND_START,   4'd15, '0, 1'b0);
      send_command(mcstb_pkg::KIND_ADVANCE, 4'd0, 32'hFFFF_FFFE, 1'b0);
      send_command(mcstb_pkg::KIND_ADVANCE, 4'd0, 32'd1, 1'b0);    // one-shot reaches its limit
      send_command(mcstb_pkg::KIND_SERVICE, 4'd0, '0, 1'b0);       // two reports
      send_command(mcstb_pkg::KIND_STOP,    4'd15, '0, 1'b0);
      send_command(mcstb_pkg::KIND_CREATE,  4'd7, '0, 1'b0);       // zero timeout
      send_command(mcstb_pkg::KIND_START,   4'd7, '0, 1'b0);
      send_command(mcstb_pkg::KIND_ADVANCE, 4'd0, '0, 1'b0);
      send_command(mcstb_pkg::KIND_KILL,    4'd0, '0, 1'b0);       // kill while running
      send_command(mcstb_pkg::KIND_SERVICE, 4'd0, '0, 1'b0);
   endtask

   task automatic test_spare_kinds();
      send_command(KIND_SPARE_A, 4'd5,  32'h5A5A_5A5A, 1'b1);
      send_command(KIND_SPARE_B, 4'd10, 32'hA5A5_A5A5, 1'b0);
   endtask

   // ------------------------------------------------------------------
   // Random traffic
   // ------------------------------------------------------------------
   function automatic logic [COUNT_W-1:0] pick_timeout();
      int r = $urandom_range(99);
      if (r < 5)  return '0;
      if (r < 10) return COUNT_MAX;
      if (r < 20) return $urandom;
      return $urandom_range(64, 1);
   endfunction

   function automatic logic [COUNT_W-1:0] pick_elapsed();
      int r = $urandom_range(99);
      if (r < 8)  return '0;
      if (r < 13) return COUNT_MAX;
      if (r < 23) return $urandom;
      return $urandom_range(40, 1);
   endfunction

   // Mix weighted towards create, start, advance and service so that plenty of
   // slots run and expire; kill, stop and spare kinds act as disturbance.
   task automatic test_random_traffic(input int n_items, input int idle_pct,
                                      input int stall_pct);
      int                 r;
      logic [KW-1:0]      kind;
      logic [COUNT_W-1:0] amount;
      sender_idle_pct = idle_pct;
      rsp_stall_pct   = stall_pct;
      for (int n = 0; n < n_items; n++) begin
         r = $urandom_range(99);
         if (r < 15)      kind = mcstb_pkg::KIND_CREATE;
         else if (r < 23) kind = mcstb_pkg::KIND_KILL;
         else if (r < 39) kind = mcstb_pkg::KIND_START;
         else if (r < 46) kind = mcstb_pkg::KIND_STOP;
         else if (r < 74) kind = mcstb_pkg::KIND_ADVANCE;
         else if (r < 96) kind = mcstb_pkg::KIND_SERVICE;
         else             kind = $urandom_range(1) ? KIND_SPARE_A : KIND_SPARE_B;
         amount = (kind == mcstb_pkg::KIND_CREATE) ? pick_timeout() :
                  (kind == mcstb_pkg::KIND_ADVANCE) ? pick_elapsed() : $urandom;
         send_command(kind, IW'($urandom_range(NUM_SLOTS - 1)), amount,
                      1'($urandom_range(1)));
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.kind          = mcstb_pkg::KIND_CREATE;
      req_ch.timer_id      = '0;
      req_ch.amount        = '0;
      req_ch.reload_enable = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_slot_lifecycle();
      test_expiry_and_reload();
      test_spare_kinds();

      // four idling phases, roughly 500 items in all
      test_random_traffic(125, 0, 0);
      test_random_traffic(125, 55, 0);
      test_random_traffic(125, 0, 55);
      test_random_traffic(125, 18, 18);

      req_ch.valid <= 1'b0;
      while (owed_reports.size() != 0) @(posedge clock);
      // allow well over the length of one sweep for stray results
      repeat (4 * NUM_SLOTS) @(posedge clock);

      if (!mismatch_seen)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #(5_000_000);
      $display("Test completed with failures");
      $finish;
   end

endmodule
